// File: hdl/table_interp_time_delta_assert.svh
// assertion macros shared by the table interpolation modules
`ifndef TABLE_INTERP_TIME_DELTA_ASSERT_SVH
`define TABLE_INTERP_TIME_DELTA_ASSERT_SVH

// same-cycle implication, disabled during reset
`define TITD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define TITD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/titd_pkg.sv
package titd_pkg;

   // default table size
   localparam int TABLE_DEPTH_DEFAULT = 1024;

   // field widths
   localparam int MODE_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int DIST_W    = 24;
   localparam int TIME_W    = 32;
   localparam int DELTA_W   = 33;

   // product of time difference and distance offset, and its serial divide
   localparam int PROD_W    = TIME_W + DIST_W;
   localparam int DIV_STEPS = PROD_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // item modes
   typedef enum logic [MODE_W-1:0] {
      MODE_CLEAR = 2'd0,
      MODE_LOAD  = 2'd1,
      MODE_QUERY = 2'd2
   } mode_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_ORDER = 2'd3
   } status_type;

   // controller states
   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SEARCH_RD,
      S_SEARCH_CMP,
      S_FETCH_HI,
      S_CAPTURE,
      S_PREP,
      S_MULT,
      S_DIV,
      S_FINISH,
      S_OUT
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic latch;
      logic exec;
      logic search_init;
      logic search_rd;
      logic search_cmp;
      logic fetch_lo;
      logic fetch_hi;
      logic capture_hi;
      logic prep;
      logic mult;
      logic div_step;
      logic finish;
      logic out_load;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic query_ok;
      logic search_done;
      logic div_last;
   } sts_type;

endpackage

// File: hdl/titd_ram.sv
module titd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/titd_ctrl.sv
`include "table_interp_time_delta_assert.svh"

module titd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  titd_pkg::sts_type sts,
   output titd_pkg::cmd_type cmd
);

   titd_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   // output slot can take a new result
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         titd_pkg::S_IDLE: begin
            if (req_valid) state_in = titd_pkg::S_DECODE;
         end
         titd_pkg::S_DECODE: begin
            if (sts.query_ok) state_in = titd_pkg::S_SEARCH_RD;
            else              state_in = titd_pkg::S_OUT;
         end
         titd_pkg::S_SEARCH_RD: begin
            if (sts.search_done) state_in = titd_pkg::S_FETCH_HI;
            else                 state_in = titd_pkg::S_SEARCH_CMP;
         end
         titd_pkg::S_SEARCH_CMP: state_in = titd_pkg::S_SEARCH_RD;
         titd_pkg::S_FETCH_HI:   state_in = titd_pkg::S_CAPTURE;
         titd_pkg::S_CAPTURE:    state_in = titd_pkg::S_PREP;
         titd_pkg::S_PREP:       state_in = titd_pkg::S_MULT;
         titd_pkg::S_MULT:       state_in = titd_pkg::S_DIV;
         titd_pkg::S_DIV: begin
            if (sts.div_last) state_in = titd_pkg::S_FINISH;
         end
         titd_pkg::S_FINISH: state_in = titd_pkg::S_OUT;
         titd_pkg::S_OUT: begin
            if (out_free) state_in = titd_pkg::S_IDLE;
         end
         default: state_in = titd_pkg::S_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         titd_pkg::S_IDLE: begin
            req_stall = 1'b0;
            cmd.latch = req_valid;
         end
         titd_pkg::S_DECODE: begin
            cmd.search_init = sts.query_ok;
            cmd.exec        = !sts.query_ok;
         end
         titd_pkg::S_SEARCH_RD: begin
            cmd.fetch_lo  = sts.search_done;
            cmd.search_rd = !sts.search_done;
         end
         titd_pkg::S_SEARCH_CMP: cmd.search_cmp = 1'b1;
         titd_pkg::S_FETCH_HI:   cmd.fetch_hi   = 1'b1;
         titd_pkg::S_CAPTURE:    cmd.capture_hi = 1'b1;
         titd_pkg::S_PREP:       cmd.prep       = 1'b1;
         titd_pkg::S_MULT:       cmd.mult       = 1'b1;
         titd_pkg::S_DIV:        cmd.div_step   = 1'b1;
         titd_pkg::S_FINISH:     cmd.finish     = 1'b1;
         titd_pkg::S_OUT:        cmd.out_load   = out_free;
         default: cmd = '0;
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load)    rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= titd_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // work on an item starts only after it was taken
   `TITD_ASSERT_NOW(a_decode_after_accept, clock, reset, state_ff == titd_pkg::S_DECODE, $past(req_valid && !req_stall), "decode without accepted item")
   // a loaded result is offered in the next cycle
   `TITD_ASSERT_NEXT(a_result_offered, clock, reset, cmd.out_load, rsp_valid_ff, "loaded result not offered")

endmodule

// File: hdl/titd_dp.sv
`include "table_interp_time_delta_assert.svh"

module titd_dp #(
   parameter int TABLE_DEPTH = titd_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  titd_pkg::cmd_type                    cmd,
   output titd_pkg::sts_type                    sts,
   input  logic [titd_pkg::MODE_W-1:0]          req_mode,
   input  logic [titd_pkg::DIST_W-1:0]          req_sample_distance,
   input  logic [titd_pkg::TIME_W-1:0]          req_sample_time,
   input  logic [titd_pkg::DIST_W-1:0]          req_query_distance,
   input  logic [titd_pkg::TIME_W-1:0]          req_query_time,
   output logic [titd_pkg::STATUS_W-1:0]        rsp_status,
   output logic [titd_pkg::TIME_W-1:0]          rsp_interp_time,
   output logic signed [titd_pkg::DELTA_W-1:0]  rsp_time_delta
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // latched item
   logic [titd_pkg::MODE_W-1:0] mode_ff;
   logic [titd_pkg::DIST_W-1:0] sd_ff, qd_ff;
   logic [titd_pkg::TIME_W-1:0] st_ff, qt_ff;

   // table bookkeeping
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [titd_pkg::DIST_W-1:0] last_dist_ff;

   // search window and fetched samples
   logic [CNT_W-1:0]            lo_ff, hi_ff, span_lh, mid;
   logic [IDX_W-1:0]            a0_in, a1_ff, rd_addr;
   logic                        clamp_in, clamp_ff;
   logic [titd_pkg::DIST_W-1:0] d0_ff, d1_ff;
   logic [titd_pkg::TIME_W-1:0] t0_ff, t1_ff;

   // interpolation arithmetic
   logic [titd_pkg::DIST_W-1:0]  off_ff, span_ff;
   logic [titd_pkg::TIME_W-1:0]  diff_ff;
   logic                         neg_ff, zero_ff;
   logic [titd_pkg::PROD_W-1:0]  prod, quo_ff;
   logic [titd_pkg::DIST_W-1:0]  rem_ff;
   logic [titd_pkg::DIST_W:0]    trial;
   logic                         trial_ge;
   logic [titd_pkg::DIV_CNT_W-1:0] div_cnt_ff;
   logic [titd_pkg::TIME_W-1:0]  quot, interp_in;

   // staged and offered results
   logic [titd_pkg::STATUS_W-1:0]       res_status_ff, res_status_in;
   logic [titd_pkg::TIME_W-1:0]         res_time_ff;
   logic [titd_pkg::DELTA_W-1:0]        res_delta_ff;
   logic [titd_pkg::STATUS_W-1:0]       rsp_status_ff;
   logic [titd_pkg::TIME_W-1:0]         rsp_time_ff;
   logic [titd_pkg::DELTA_W-1:0]        rsp_delta_ff;

   // memory ports
   logic                        wr_en;
   logic [titd_pkg::DIST_W-1:0] rd_dist;
   logic [titd_pkg::TIME_W-1:0] rd_time;

   titd_ram #(
      .WIDTH (titd_pkg::DIST_W),
      .DEPTH (TABLE_DEPTH)
   ) u_dist_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (sd_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_dist)
   );

   titd_ram #(
      .WIDTH (titd_pkg::TIME_W),
      .DEPTH (TABLE_DEPTH)
   ) u_time_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (st_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_time)
   );

   // clear, load and empty-query handling
   always_comb begin
      wr_en         = 1'b0;
      count_in      = count_ff;
      res_status_in = titd_pkg::STATUS_OK;
      case (titd_pkg::mode_type'(mode_ff))
         titd_pkg::MODE_CLEAR: count_in = '0;
         titd_pkg::MODE_LOAD: begin
            if (count_ff == CNT_W'(TABLE_DEPTH)) begin
               res_status_in = titd_pkg::STATUS_FULL;
            end else if (count_ff != '0 && sd_ff < last_dist_ff) begin
               res_status_in = titd_pkg::STATUS_ORDER;
            end else begin
               wr_en    = cmd.exec;
               count_in = count_ff + CNT_W'(1);
            end
         end
         titd_pkg::MODE_QUERY: res_status_in = titd_pkg::STATUS_EMPTY;
         default: res_status_in = titd_pkg::STATUS_OK;
      endcase
   end

   // binary search midpoint and bracket selection
   assign span_lh  = hi_ff - lo_ff;
   assign mid      = lo_ff + (span_lh >> 1);
   assign clamp_in = (lo_ff == '0) || (lo_ff >= count_ff);

   always_comb begin
      if (lo_ff == '0)            a0_in = '0;
      else if (lo_ff >= count_ff) a0_in = IDX_W'(count_ff - CNT_W'(1));
      else                        a0_in = IDX_W'(lo_ff - CNT_W'(1));
   end

   always_comb begin
      if (cmd.search_rd)     rd_addr = mid[IDX_W-1:0];
      else if (cmd.fetch_lo) rd_addr = a0_in;
      else                   rd_addr = a1_ff;
   end

   // restoring divide step
   assign prod     = diff_ff * off_ff;
   assign trial    = {rem_ff, quo_ff[titd_pkg::PROD_W-1]};
   assign trial_ge = trial >= {1'b0, span_ff};

   // final time from the lower sample and the quotient
   assign quot = quo_ff[titd_pkg::TIME_W-1:0];
   always_comb begin
      if (zero_ff)     interp_in = t0_ff;
      else if (neg_ff) interp_in = t0_ff - quot;
      else             interp_in = t0_ff + quot;
   end

   // status to controller
   assign sts.query_ok    = (titd_pkg::mode_type'(mode_ff) == titd_pkg::MODE_QUERY)
                            && (count_ff != '0);
   assign sts.search_done = lo_ff >= hi_ff;
   assign sts.div_last    = div_cnt_ff == titd_pkg::DIV_CNT_W'(titd_pkg::DIV_STEPS - 1);

   // entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff <= req_mode;
         sd_ff   <= req_sample_distance;
         st_ff   <= req_sample_time;
         qd_ff   <= req_query_distance;
         qt_ff   <= req_query_time;
      end
      if (wr_en) begin
         last_dist_ff <= sd_ff;
      end
      if (cmd.exec) begin
         res_status_ff <= res_status_in;
         res_time_ff   <= '0;
         res_delta_ff  <= '0;
      end
      if (cmd.search_init) begin
         lo_ff <= '0;
         hi_ff <= count_ff;
      end
      if (cmd.search_cmp) begin
         if (rd_dist <= qd_ff) lo_ff <= mid + CNT_W'(1);
         else                  hi_ff <= mid;
      end
      if (cmd.fetch_lo) begin
         a1_ff    <= lo_ff[IDX_W-1:0];
         clamp_ff <= clamp_in;
      end
      if (cmd.fetch_hi) begin
         d0_ff <= rd_dist;
         t0_ff <= rd_time;
      end
      if (cmd.capture_hi) begin
         d1_ff <= rd_dist;
         t1_ff <= rd_time;
      end
      if (cmd.prep) begin
         off_ff  <= qd_ff - d0_ff;
         span_ff <= d1_ff - d0_ff;
         neg_ff  <= t1_ff < t0_ff;
         diff_ff <= (t1_ff < t0_ff) ? (t0_ff - t1_ff) : (t1_ff - t0_ff);
         zero_ff <= clamp_ff || (d1_ff == d0_ff);
      end
      if (cmd.mult) begin
         quo_ff     <= prod;
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff     <= trial_ge ? titd_pkg::DIST_W'(trial - {1'b0, span_ff})
                                : trial[titd_pkg::DIST_W-1:0];
         quo_ff     <= {quo_ff[titd_pkg::PROD_W-2:0], trial_ge};
         div_cnt_ff <= div_cnt_ff + titd_pkg::DIV_CNT_W'(1);
      end
      if (cmd.finish) begin
         res_status_ff <= titd_pkg::STATUS_OK;
         res_time_ff   <= interp_in;
         res_delta_ff  <= {1'b0, interp_in} - {1'b0, qt_ff};
      end
      if (cmd.out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_time_ff   <= res_time_ff;
         rsp_delta_ff  <= res_delta_ff;
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_interp_time = rsp_time_ff;
   assign rsp_time_delta  = rsp_delta_ff;

   // the table fill changes only when an item is carried out
   `TITD_ASSERT_NEXT(a_count_held, clock, reset, !cmd.exec, count_ff == $past(count_ff), "entry count changed outside exec")
   // an interpolated time lies between its two samples
   `TITD_ASSERT_NEXT(a_interp_bounded, clock, reset, cmd.finish && !zero_ff, (res_time_ff >= (neg_ff ? t1_ff : t0_ff)) && (res_time_ff <= (neg_ff ? t0_ff : t1_ff)), "interpolated time outside samples")

endmodule

// File: hdl/table_interp_time_delta.sv
// channel  direction  handshake            payload
// req      in         req_valid/req_stall  mode, sample and query distance/time
// rsp      out        rsp_valid/rsp_stall  status, interp_time, time_delta
//
// Clear and load items go from the decode state straight to the output state.
// A query runs S search steps, S at most ceil(log2(entries + 1)); each step reads
// the distance RAM and then compares, and a restoring divider over the 56-bit
// product then yields one quotient bit per cycle.
// Of the table, reset clears the entry count only; the sample RAMs need no clearing pass.
// A stalled result holds in the output register while the next item runs, then
// that item waits for the output register with req_stall high.
module table_interp_time_delta #(
   parameter int TABLE_DEPTH = titd_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [titd_pkg::MODE_W-1:0]          req_mode,
   input  logic [titd_pkg::DIST_W-1:0]          req_sample_distance,
   input  logic [titd_pkg::TIME_W-1:0]          req_sample_time,
   input  logic [titd_pkg::DIST_W-1:0]          req_query_distance,
   input  logic [titd_pkg::TIME_W-1:0]          req_query_time,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [titd_pkg::STATUS_W-1:0]        rsp_status,
   output logic [titd_pkg::TIME_W-1:0]          rsp_interp_time,
   output logic signed [titd_pkg::DELTA_W-1:0]  rsp_time_delta
);

   titd_pkg::cmd_type cmd;
   titd_pkg::sts_type sts;

   // sequencer
   titd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // table, search and interpolation datapath
   titd_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_mode            (req_mode),
      .req_sample_distance (req_sample_distance),
      .req_sample_time     (req_sample_time),
      .req_query_distance  (req_query_distance),
      .req_query_time      (req_query_time),
      .rsp_status          (rsp_status),
      .rsp_interp_time     (rsp_interp_time),
      .rsp_time_delta      (rsp_time_delta)
   );

endmodule
